### src/quoted_word_splitter_assert.svh
// Assertion macros for the word splitter; they use clk and rst_n of the enclosing module.
`ifndef QUOTED_WORD_SPLITTER_ASSERT_SVH
`define QUOTED_WORD_SPLITTER_ASSERT_SVH

`ifndef SYNTHESIS
`define QWS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define QWS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define QWS_ASSERT_ALWAYS(label, expr, msg)
`define QWS_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### src/qws_pkg.sv
package qws_pkg;

    localparam int COUNT_BITS = 10;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int WIDE_W     = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = ((8 + COUNT_BITS + 1 + 7) / 8) * 8;
    localparam int QDEPTH     = 4;
    localparam int QCNT_W     = 3;

    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ARGS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_COUNT = 1'd1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS_CTL = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_S  = 8'h73;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    typedef enum logic [1:0] {
        M_BETWEEN = 2'd0,
        M_COMMENT = 2'd1,
        M_WORD    = 2'd2,
        M_ESCAPE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } quote_t;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            data;
        logic [COUNT_BITS-1:0] number;
        logic                  dropped;
        logic                  last;
    } result_t;

endpackage

### src/quoted_word_splitter.sv
// Results of an accepted item are registered into the result queue ahead of the output.
// Throughput: one item per cycle while items give at most one result each and
// the output accepts them; an item that gives two or three results holds off the
// next item, set by the single output port draining a four-entry result queue.
// Reset: asynchronous, active low; clears parser state, word count and queue.
module quoted_word_splitter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [qws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qws_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [qws_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,   // end_of_text
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [qws_pkg::OUT_DATA_W-1:0]  m_tdata,   // out_byte, word_number, dropped, zero pad
    output logic                            m_tuser,   // kind
    output logic                            m_tlast    // last
);
    import qws_pkg::*;

    mode_t                  mode_reg, mode_next;
    quote_t                 quote_reg, quote_next;
    logic                   had_quote_reg, had_quote_next;
    logic                   nonempty_reg, nonempty_next;
    logic [COUNT_BITS-1:0]  word_count_reg, word_count_next;
    logic [CFG_W-1:0]       max_args_reg;

    result_t                queue_reg [QDEPTH];
    result_t                queue_next [QDEPTH];
    logic [QCNT_W-1:0]      cnt_reg, cnt_next;

    logic [7:0]             c;
    logic                   finish;
    logic                   do_word;
    logic                   ended;
    logic [1:0]             n;
    logic [7:0]             rb [3];
    logic                   rk [3];
    logic [7:0]             qc;
    logic                   is_space;
    logic [COUNT_BITS-1:0]  num;
    logic                   drop;
    logic                   push;
    logic                   pop;
    logic [QCNT_W-1:0]      base;
    result_t                res [3];
    result_t                head;

    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= QCNT_W'(1));
    assign m_tvalid = (cnt_reg != '0);

    assign num  = (word_count_reg == CMAX) ? CMAX : word_count_reg + 1'b1;
    assign drop = (word_count_reg == CMAX) || (WIDE_W'(num) > WIDE_W'(max_args_reg));

    // Parser: all results of one item share the word number taken before the item.
    always_comb
    begin
        c               = s_tdata[7:0];
        mode_next       = mode_reg;
        quote_next      = quote_reg;
        had_quote_next  = had_quote_reg;
        nonempty_next   = nonempty_reg;
        finish          = 1'b0;
        do_word         = 1'b0;
        ended           = 1'b0;
        n               = 2'd0;
        qc              = CH_NUL;
        for (int k = 0; k < 3; k++)
        begin
            rb[k] = CH_NUL;
            rk[k] = KIND_BYTE;
        end
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);

        if (c == CH_NUL)
        begin
            finish = 1'b1;
        end
        else
        begin
            case (mode_reg)
                M_BETWEEN:
                begin
                    if (!is_space)
                    begin
                        if (c == CH_HASH)
                        begin
                            mode_next = M_COMMENT;
                        end
                        else
                        begin
                            quote_next     = Q_NONE;
                            had_quote_next = 1'b0;
                            nonempty_next  = 1'b0;
                            mode_next      = M_WORD;
                            do_word        = 1'b1;
                        end
                    end
                end
                M_COMMENT:
                begin
                    if (c == CH_LF)
                    begin
                        mode_next = M_BETWEEN;
                    end
                end
                M_WORD:
                begin
                    do_word = 1'b1;
                end
                default:
                begin
                    mode_next = M_WORD;
                    case (c)
                        CH_HASH, CH_BSLASH, CH_SPACE, CH_TAB, CH_LF:
                        begin
                            rb[n] = c; n = n + 2'd1; nonempty_next = 1'b1;
                        end
                        CH_LOW_R:
                        begin
                            rb[n] = CH_CR; n = n + 2'd1; nonempty_next = 1'b1;
                        end
                        CH_LOW_N:
                        begin
                            rb[n] = CH_LF; n = n + 2'd1; nonempty_next = 1'b1;
                        end
                        CH_LOW_T:
                        begin
                            rb[n] = CH_TAB; n = n + 2'd1; nonempty_next = 1'b1;
                        end
                        CH_LOW_S:
                        begin
                            rb[n] = CH_SPACE; n = n + 2'd1; nonempty_next = 1'b1;
                        end
                        CH_LOW_B:
                        begin
                            rb[n] = CH_BS_CTL; n = n + 2'd1; nonempty_next = 1'b1;
                        end
                        CH_SQUOTE, CH_DQUOTE:
                        begin
                            // keep the backslash for the other kind of quote
                            if ((quote_reg == Q_SINGLE && c == CH_DQUOTE)
                                || (quote_reg == Q_DOUBLE && c == CH_SQUOTE))
                            begin
                                rb[n] = CH_BSLASH; n = n + 2'd1;
                            end
                            rb[n] = c; n = n + 2'd1; nonempty_next = 1'b1;
                        end
                        default:
                        begin
                            rb[n] = CH_BSLASH; n = n + 2'd1;
                            rb[n] = c; n = n + 2'd1; nonempty_next = 1'b1;
                        end
                    endcase
                end
            endcase

            if (do_word)
            begin
                qc = (quote_next == Q_SINGLE) ? CH_SQUOTE :
                     (quote_next == Q_DOUBLE) ? CH_DQUOTE : CH_NUL;
                if (quote_next != Q_NONE && c == qc)
                begin
                    quote_next = Q_NONE;
                end
                else if (is_space)
                begin
                    if (quote_next != Q_NONE)
                    begin
                        rb[n] = c; n = n + 2'd1; nonempty_next = 1'b1;
                    end
                    else
                    begin
                        if (nonempty_next || had_quote_next)
                        begin
                            rk[n] = KIND_END; n = n + 2'd1; ended = 1'b1;
                        end
                        quote_next     = Q_NONE;
                        had_quote_next = 1'b0;
                        nonempty_next  = 1'b0;
                        mode_next      = M_BETWEEN;
                    end
                end
                else if (c == CH_SQUOTE || c == CH_DQUOTE)
                begin
                    if (quote_next != Q_NONE)
                    begin
                        rb[n] = c; n = n + 2'd1; nonempty_next = 1'b1;
                    end
                    else
                    begin
                        had_quote_next = 1'b1;
                        quote_next     = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
                    end
                end
                else if (c == CH_BSLASH)
                begin
                    mode_next = M_ESCAPE;
                end
                else
                begin
                    rb[n] = c; n = n + 2'd1; nonempty_next = 1'b1;
                end
            end
            finish = s_tlast;
        end

        if (finish)
        begin
            // a trailing backslash stands for itself
            if (mode_next == M_ESCAPE)
            begin
                rb[n] = CH_BSLASH; n = n + 2'd1; nonempty_next = 1'b1;
                mode_next = M_WORD;
            end
            if (mode_next == M_WORD && (nonempty_next || had_quote_next))
            begin
                rk[n] = KIND_END; n = n + 2'd1; ended = 1'b1;
            end
            quote_next     = Q_NONE;
            had_quote_next = 1'b0;
            nonempty_next  = 1'b0;
            mode_next      = M_BETWEEN;
        end

        word_count_next = ended ? num : word_count_reg;
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            res[k].kind    = rk[k];
            res[k].data    = rb[k];
            res[k].number  = num;
            res[k].dropped = drop;
            res[k].last    = (2'(k + 1) == n);
        end
    end

    // Result queue: shift out at the head, append this item's results behind.
    always_comb
    begin
        base = cnt_reg - QCNT_W'(pop);
        for (int i = 0; i < QDEPTH; i++)
        begin
            queue_next[i] = (pop && i < QDEPTH - 1) ? queue_reg[(i + 1) % QDEPTH] : queue_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                if (push && 2'(k) < n && (base + QCNT_W'(k)) == QCNT_W'(i))
                begin
                    queue_next[i] = res[k];
                end
            end
        end
        cnt_next = base + (push ? QCNT_W'(n) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_BETWEEN;
            quote_reg      <= Q_NONE;
            had_quote_reg  <= 1'b0;
            nonempty_reg   <= 1'b0;
            word_count_reg <= '0;
            max_args_reg   <= '1;
            cnt_reg        <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                mode_reg      <= mode_next;
                quote_reg     <= quote_next;
                had_quote_reg <= had_quote_next;
                nonempty_reg  <= nonempty_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_ARGS:
                    begin
                        max_args_reg <= cfg_data;
                    end
                    REG_START_COUNT:
                    begin
                        if (WIDE_W'(cfg_data) > WIDE_W'(CMAX))
                        begin
                            word_count_reg <= CMAX;
                        end
                        else
                        begin
                            word_count_reg <= COUNT_BITS'(cfg_data);
                        end
                    end
                    default:
                    begin
                        max_args_reg <= max_args_reg;
                    end
                endcase
            end
            else if (push)
            begin
                word_count_reg <= word_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
    end

    assign head    = queue_reg[0];
    assign m_tdata = OUT_DATA_W'({head.dropped, head.number, head.data});
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

`include "quoted_word_splitter_assert.svh"

    `QWS_ASSERT_ALWAYS(a_queue_bound, cnt_reg <= QCNT_W'(QDEPTH), "result queue overflow")
    `QWS_ASSERT_NEXT(a_results_follow, push && n != 2'd0, m_tvalid, "item results not queued")
    `QWS_ASSERT_NEXT(a_item_unbroken, pop && !m_tlast, m_tvalid, "item results broken up")
    `QWS_ASSERT_NEXT(a_count_monotonic, push && !cfg_we,
        word_count_reg >= $past(word_count_reg), "word count went backward")

endmodule
